/* sv/obb_pkg.sv */
package obb_pkg;

	localparam int CENTER_BITS = 20;
	localparam int AXIS_BITS   = 16;
	localparam int EXTENT_BITS = 16;
	localparam int AXIS_COUNT  = 15;
	localparam int FRAC_BITS   = 12;

	// widths of derived quantities
	localparam int DB = CENTER_BITS + 1;        // center difference
	localparam int LB = 2 * AXIS_BITS + 1;      // candidate axis component
	localparam int PD = DB + LB + 2;            // d . L
	localparam int PR = AXIS_BITS + LB + 2;     // box axis . L
	localparam int TERM_W = 64;                 // radius term, kept modulo 2^64
	localparam int SUM_W  = TERM_W + 3;         // sum of six terms
	localparam int LHS_W  = PD + FRAC_BITS;
	localparam int IDX_W  = $clog2(AXIS_COUNT);

	typedef logic signed [AXIS_BITS-1:0]  axc_t;
	typedef axc_t [2:0]                   axv_t;
	typedef logic signed [DB-1:0]         dc_t;
	typedef dc_t [2:0]                    dv_t;
	typedef logic [EXTENT_BITS-1:0]       ec_t;
	typedef ec_t [2:0]                    ev_t;
	typedef logic signed [LB-1:0]         lc_t;
	typedef lc_t [2:0]                    lv_t;

	typedef struct packed {
		axv_t [2:0]            aa;
		axv_t [2:0]            ba;
		dv_t                   d;
		ev_t                   ea;
		ev_t                   eb;
		lv_t [AXIS_COUNT-1:0]  axes;
		logic                  sep;
	} pair_t;

	function automatic logic signed [PR-1:0] dot_ax(axv_t a, lv_t l);
		logic signed [PR-1:0] s;
		s = PR'(a[0]) * PR'(l[0]) + PR'(a[1]) * PR'(l[1]) + PR'(a[2]) * PR'(l[2]);
		return s;
	endfunction

	function automatic logic signed [PD-1:0] dot_d(dv_t a, lv_t l);
		logic signed [PD-1:0] s;
		s = PD'(a[0]) * PD'(l[0]) + PD'(a[1]) * PD'(l[1]) + PD'(a[2]) * PD'(l[2]);
		return s;
	endfunction

endpackage

/* sv/obb_front.sv */
module obb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               vld_i,
	input  logic [3*obb_pkg::CENTER_BITS-1:0]  ac,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    a0,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    a1,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    a2,
	input  logic [3*obb_pkg::EXTENT_BITS-1:0]  ae,
	input  logic [3*obb_pkg::CENTER_BITS-1:0]  bc,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    b0,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    b1,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    b2,
	input  logic [3*obb_pkg::EXTENT_BITS-1:0]  be,
	output logic                               vld_o,
	output obb_pkg::pair_t                     pair_o
);
	import obb_pkg::*;

	pair_t p;
	logic  vld_s1;
	pair_t pair_s1;

	always_comb begin
		p = '0;
		p.aa[0] = axv_t'(a0);
		p.aa[1] = axv_t'(a1);
		p.aa[2] = axv_t'(a2);
		p.ba[0] = axv_t'(b0);
		p.ba[1] = axv_t'(b1);
		p.ba[2] = axv_t'(b2);
		p.ea = ev_t'(ae);
		p.eb = ev_t'(be);
		for (int i = 0; i < 3; i++) begin
			p.d[i] = DB'($signed(ac[i*CENTER_BITS +: CENTER_BITS]))
				- DB'($signed(bc[i*CENTER_BITS +: CENTER_BITS]));
			p.axes[i]     = '{LB'(p.aa[i][2]), LB'(p.aa[i][1]), LB'(p.aa[i][0])};
			p.axes[3 + i] = '{LB'(p.ba[i][2]), LB'(p.ba[i][1]), LB'(p.ba[i][0])};
		end
		// cross products A[i] x B[j]
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p.axes[6 + 3*i + j][0] = LB'(p.aa[i][1]) * LB'(p.ba[j][2])
					- LB'(p.aa[i][2]) * LB'(p.ba[j][1]);
				p.axes[6 + 3*i + j][1] = LB'(p.aa[i][2]) * LB'(p.ba[j][0])
					- LB'(p.aa[i][0]) * LB'(p.ba[j][2]);
				p.axes[6 + 3*i + j][2] = LB'(p.aa[i][0]) * LB'(p.ba[j][1])
					- LB'(p.aa[i][1]) * LB'(p.ba[j][0]);
			end
		end
		p.sep = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s1 <= p;
		end
	end

	assign vld_o  = vld_s1;
	assign pair_o = pair_s1;

endmodule

/* sv/obb_cell.sv */
module obb_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [obb_pkg::IDX_W-1:0]   idx,
	input  logic                        vld_i,
	input  obb_pkg::pair_t              pair_i,
	output logic                        vld_o,
	output obb_pkg::pair_t              pair_o
);
	import obb_pkg::*;

	lv_t                  l;
	logic                 vld_s1, vld_s2, vld_s3;
	pair_t                pair_s1, pair_s2, pair_s3;
	logic                 zero_s1, zero_s2;
	logic signed [PD-1:0] dd_s1;
	logic signed [PR-1:0] ra_s1 [3];
	logic signed [PR-1:0] rb_s1 [3];
	logic [LHS_W-1:0]     lhs_s2;
	logic [TERM_W-1:0]    ta_s2 [3];
	logic [TERM_W-1:0]    tb_s2 [3];
	logic [PD-1:0]        dmag;
	logic [PR-1:0]        amag [3];
	logic [PR-1:0]        bmag [3];
	logic [SUM_W-1:0]     rhs;
	logic                 sep;
	pair_t                pair_nx;

	assign l = pair_i.axes[idx];

	always_comb begin
		dmag = dd_s1[PD-1] ? PD'(-dd_s1) : PD'(dd_s1);
		for (int i = 0; i < 3; i++) begin
			amag[i] = ra_s1[i][PR-1] ? PR'(-ra_s1[i]) : PR'(ra_s1[i]);
			bmag[i] = rb_s1[i][PR-1] ? PR'(-rb_s1[i]) : PR'(rb_s1[i]);
		end
		rhs = '0;
		for (int i = 0; i < 3; i++) begin
			rhs = rhs + SUM_W'(ta_s2[i]) + SUM_W'(tb_s2[i]);
		end
		sep = !zero_s2 && (lhs_s2 > LHS_W'(rhs));
		pair_nx     = pair_s2;
		pair_nx.sep = pair_s2.sep | sep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// projections onto the candidate axis
			pair_s1 <= pair_i;
			zero_s1 <= (l[0] == '0) && (l[1] == '0) && (l[2] == '0);
			dd_s1   <= dot_d(pair_i.d, l);
			for (int i = 0; i < 3; i++) begin
				ra_s1[i] <= dot_ax(pair_i.aa[i], l);
				rb_s1[i] <= dot_ax(pair_i.ba[i], l);
			end
			// scale by extents; terms wrap at 64 bits
			pair_s2 <= pair_s1;
			zero_s2 <= zero_s1;
			lhs_s2  <= LHS_W'(dmag) << FRAC_BITS;
			for (int i = 0; i < 3; i++) begin
				ta_s2[i] <= TERM_W'(amag[i]) * TERM_W'(pair_s1.ea[i]);
				tb_s2[i] <= TERM_W'(bmag[i]) * TERM_W'(pair_s1.eb[i]);
			end
			// compare and fold into the running flag
			pair_s3 <= pair_nx;
		end
	end

	assign vld_o  = vld_s3;
	assign pair_o = pair_s3;

endmodule

/* sv/obb_separating_axis_test.sv */
// OBB-OBB separating axis test, 15 candidate axes.
// Input channel: in_valid / in_stall with one box pair per request
// (center, three axes, half extents for boxes A and B, packed Q.12).
// Output channel: out_valid / out_stall carrying colliding, 1 when no
// candidate axis separates the boxes (touching counts as colliding).
// Structure: a front stage unpacks the request and forms the nine cross
// product axes; then a chain of 15 identical cells follows, one per axis.
// Each cell projects the center offset and both boxes on its axis over
// three stages and ORs its verdict into a separated flag that travels
// with the request to the next cell.
// Throughput: one request per cycle while not stalled. Depth: 46
// register stages (1 front stage + 15 cells x 3 stages); the front
// stage loads at the accepting edge.
// Stall: the whole chain holds while out_valid is high and out_stall is
// high; in_stall is raised in exactly that case. The last cell stage is
// the output register, so nothing is dropped or repeated.
// Reset: arst_n clears all valid bits; no requests are in flight after.
module obb_separating_axis_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [3*obb_pkg::CENTER_BITS-1:0]  a_center,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    a_axis_first,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    a_axis_second,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    a_axis_third,
	input  logic [3*obb_pkg::EXTENT_BITS-1:0]  a_half_extents,
	input  logic [3*obb_pkg::CENTER_BITS-1:0]  b_center,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    b_axis_first,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    b_axis_second,
	input  logic [3*obb_pkg::AXIS_BITS-1:0]    b_axis_third,
	input  logic [3*obb_pkg::EXTENT_BITS-1:0]  b_half_extents,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               colliding
);
	import obb_pkg::*;

	logic  adv;
	logic  vld  [AXIS_COUNT+1];
	pair_t pair [AXIS_COUNT+1];

	// chain advances unless a finished result is held by the receiver
	assign in_stall = out_valid && out_stall;
	assign adv      = !in_stall;

	obb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (in_valid),
		.ac     (a_center),
		.a0     (a_axis_first),
		.a1     (a_axis_second),
		.a2     (a_axis_third),
		.ae     (a_half_extents),
		.bc     (b_center),
		.b0     (b_axis_first),
		.b1     (b_axis_second),
		.b2     (b_axis_third),
		.be     (b_half_extents),
		.vld_o  (vld[0]),
		.pair_o (pair[0])
	);

	// one cell per candidate axis, in test order
	for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_cell
		obb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.idx    (IDX_W'(k)),
			.vld_i  (vld[k]),
			.pair_i (pair[k]),
			.vld_o  (vld[k+1]),
			.pair_o (pair[k+1])
		);
	end

	assign out_valid = vld[AXIS_COUNT];
	assign colliding = !pair[AXIS_COUNT].sep;

endmodule

/* sim/obb_separating_axis_test_tb.sv */
module obb_separating_axis_test_tb;
	import obb_pkg::*;

	localparam int CW = 3 * CENTER_BITS;
	localparam int AW = 3 * AXIS_BITS;
	localparam int EW = 3 * EXTENT_BITS;
	localparam int ONE = 1 << FRAC_BITS;      // 1.0 in Q.12
	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_AT = 300;              // sender drains the pipe here once
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CW-1:0] a_center = '0;
	logic [AW-1:0] a_axis_first = '0;
	logic [AW-1:0] a_axis_second = '0;
	logic [AW-1:0] a_axis_third = '0;
	logic [EW-1:0] a_half_extents = '0;
	logic [CW-1:0] b_center = '0;
	logic [AW-1:0] b_axis_first = '0;
	logic [AW-1:0] b_axis_second = '0;
	logic [AW-1:0] b_axis_third = '0;
	logic [EW-1:0] b_half_extents = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic colliding;

	obb_separating_axis_test dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_center(a_center), .a_axis_first(a_axis_first),
		.a_axis_second(a_axis_second), .a_axis_third(a_axis_third),
		.a_half_extents(a_half_extents),
		.b_center(b_center), .b_axis_first(b_axis_first),
		.b_axis_second(b_axis_second), .b_axis_third(b_axis_third),
		.b_half_extents(b_half_extents),
		.out_valid(out_valid), .out_stall(out_stall), .colliding(colliding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one directed box pair; want_en marks rows whose verdict is obvious
	typedef struct {
		logic [CW-1:0] ac, bc;
		logic [AW-1:0] a1, a2, a3, b1, b2, b3;
		logic [EW-1:0] ae, be;
		bit want_en;
		bit want;
	} pair_row_t;

	pair_row_t rows[$];
	bit verdict_q[$];         // expected colliding flags, oldest first
	int errors = 0;
	int cycles = 0;
	bit row_want_en = 0;      // typed verdict of the request on the bus
	bit row_want = 0;

	function automatic logic [CW-1:0] pk_c(int x, int y, int z);
		return {CENTER_BITS'(z), CENTER_BITS'(y), CENTER_BITS'(x)};
	endfunction

	function automatic logic [AW-1:0] pk_a(int x, int y, int z);
		return {AXIS_BITS'(z), AXIS_BITS'(y), AXIS_BITS'(x)};
	endfunction

	function automatic logic [EW-1:0] pk_e(int x, int y, int z);
		return {EXTENT_BITS'(z), EXTENT_BITS'(y), EXTENT_BITS'(x)};
	endfunction

	// Exact SAT verdict. Radius terms wrap at 64 bits like the block does;
	// sums and the shifted distance are compared at 128 bits.
	function automatic bit sat_overlap(logic [CW-1:0] ac, logic [AW-1:0] a1, a2, a3,
			logic [EW-1:0] ae, logic [CW-1:0] bc, logic [AW-1:0] b1, b2, b3,
			logic [EW-1:0] be);
		longint dv[3], aa[3][3], ba[3][3], ln[15][3];
		logic [63:0] ea[3], eb[3];
		logic [AW-1:0] aw[3], bw[3];
		longint p;
		logic [63:0] mag, term;
		logic [127:0] lhs, rhs;
		int k;
		aw[0] = a1; aw[1] = a2; aw[2] = a3;
		bw[0] = b1; bw[1] = b2; bw[2] = b3;
		for (int i = 0; i < 3; i++) begin
			dv[i] = longint'($signed(ac[i*CENTER_BITS +: CENTER_BITS]))
				- longint'($signed(bc[i*CENTER_BITS +: CENTER_BITS]));
			ea[i] = 64'(ae[i*EXTENT_BITS +: EXTENT_BITS]);
			eb[i] = 64'(be[i*EXTENT_BITS +: EXTENT_BITS]);
			for (int c = 0; c < 3; c++) begin
				aa[i][c] = longint'($signed(aw[i][c*AXIS_BITS +: AXIS_BITS]));
				ba[i][c] = longint'($signed(bw[i][c*AXIS_BITS +: AXIS_BITS]));
			end
		end
		for (int i = 0; i < 3; i++)
			for (int c = 0; c < 3; c++) begin
				ln[i][c] = aa[i][c];
				ln[3+i][c] = ba[i][c];
			end
		k = 6;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				ln[k][0] = aa[i][1] * ba[j][2] - aa[i][2] * ba[j][1];
				ln[k][1] = aa[i][2] * ba[j][0] - aa[i][0] * ba[j][2];
				ln[k][2] = aa[i][0] * ba[j][1] - aa[i][1] * ba[j][0];
				k++;
			end
		for (int x = 0; x < 15; x++) begin
			if (ln[x][0] == 0 && ln[x][1] == 0 && ln[x][2] == 0)
				continue;    // parallel cross or null axis
			p = dv[0] * ln[x][0] + dv[1] * ln[x][1] + dv[2] * ln[x][2];
			mag = p < 0 ? 64'(-p) : 64'(p);
			lhs = {64'b0, mag} << FRAC_BITS;
			rhs = '0;
			for (int i = 0; i < 3; i++) begin
				p = aa[i][0] * ln[x][0] + aa[i][1] * ln[x][1] + aa[i][2] * ln[x][2];
				mag = p < 0 ? 64'(-p) : 64'(p);
				term = mag * ea[i];
				rhs = rhs + {64'b0, term};
				p = ba[i][0] * ln[x][0] + ba[i][1] * ln[x][1] + ba[i][2] * ln[x][2];
				mag = p < 0 ? 64'(-p) : 64'(p);
				term = mag * eb[i];
				rhs = rhs + {64'b0, term};
			end
			if (lhs > rhs)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// short gaps mostly, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random axis component near unit scale, sometimes anything at all
	function automatic int rnd_comp();
		if ($urandom_range(0, 9) == 0)
			return int'($signed(AXIS_BITS'($urandom)));
		return $urandom_range(0, 2 * ONE) - ONE;
	endfunction

	task automatic put_pair(pair_row_t r);
		a_center = r.ac; a_axis_first = r.a1; a_axis_second = r.a2;
		a_axis_third = r.a3; a_half_extents = r.ae;
		b_center = r.bc; b_axis_first = r.b1; b_axis_second = r.b2;
		b_axis_third = r.b3; b_half_extents = r.be;
		row_want_en = r.want_en;
		row_want = r.want;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic pair_row_t rnd_pair();
		pair_row_t r;
		int sel;
		sel = $urandom_range(0, 9);
		r.want_en = 0;
		r.want = 0;
		if (sel == 0) begin
			// raw bits: every field bit gets both values
			r.ac = CW'({$urandom, $urandom}); r.bc = CW'({$urandom, $urandom});
			r.a1 = AW'({$urandom, $urandom}); r.a2 = AW'({$urandom, $urandom});
			r.a3 = AW'({$urandom, $urandom}); r.ae = EW'({$urandom, $urandom});
			r.b1 = AW'({$urandom, $urandom}); r.b2 = AW'({$urandom, $urandom});
			r.b3 = AW'({$urandom, $urandom}); r.be = EW'({$urandom, $urandom});
		end else begin
			// nearby boxes so both verdicts show up often
			r.ac = pk_c($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
				$urandom_range(0, 32767) - 16384);
			r.bc = pk_c($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
				$urandom_range(0, 32767) - 16384);
			r.a1 = pk_a(rnd_comp(), rnd_comp(), rnd_comp());
			r.a2 = pk_a(rnd_comp(), rnd_comp(), rnd_comp());
			r.a3 = pk_a(rnd_comp(), rnd_comp(), rnd_comp());
			if (sel == 1) begin
				r.b1 = r.a1; r.b2 = r.a2; r.b3 = r.a3;   // parallel crosses
			end else begin
				r.b1 = pk_a(rnd_comp(), rnd_comp(), rnd_comp());
				r.b2 = pk_a(rnd_comp(), rnd_comp(), rnd_comp());
				r.b3 = pk_a(rnd_comp(), rnd_comp(), rnd_comp());
			end
			if (sel == 2) r.a2 = '0;                     // a null axis
			r.ae = pk_e($urandom_range(0, 3 * ONE), $urandom_range(0, 3 * ONE),
				$urandom_range(0, 3 * ONE));
			r.be = pk_e($urandom_range(0, 3 * ONE), $urandom_range(0, 3 * ONE),
				$urandom_range(0, 3 * ONE));
		end
		return r;
	endfunction

	// receiver back-pressure: runs of stall, runs of none
	always @(negedge clk) begin
		if (!arst_n)
			out_stall = 1'b0;
		else if (cycles % 2000 < 300)
			out_stall = 1'b0;
		else if ($urandom_range(0, 99) < 3)
			out_stall = 1'b1;
		else if (out_stall && $urandom_range(0, 99) < 60)
			out_stall = 1'b1;
		else
			out_stall = ($urandom_range(0, 99) < 15);
	end

	// accept requests into the verdict queue; check each delivered result
	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (in_valid && !in_stall) begin
				want = sat_overlap(a_center, a_axis_first, a_axis_second, a_axis_third,
					a_half_extents, b_center, b_axis_first, b_axis_second,
					b_axis_third, b_half_extents);
				if (row_want_en) want = row_want;
				verdict_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result colliding=%0b", $time, colliding);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (colliding !== want) begin
						$display("%0t: colliding expected %0b actual %0b",
							$time, want, colliding);
						errors++;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("obb_separating_axis_test_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		pair_row_t r;
		pair_row_t z;
		z = '{ac: '0, bc: '0, a1: '0, a2: '0, a3: '0, b1: '0, b2: '0, b3: '0,
			ae: '0, be: '0, want_en: 1, want: 1};

		// all fields zero: every axis null, nothing separates
		rows.push_back(z);
		// unit axis-aligned boxes, extents 1.0
		r = z;
		r.a1 = pk_a(ONE, 0, 0); r.a2 = pk_a(0, ONE, 0); r.a3 = pk_a(0, 0, ONE);
		r.b1 = r.a1; r.b2 = r.a2; r.b3 = r.a3;
		r.ae = pk_e(ONE, ONE, ONE); r.be = r.ae;
		rows.push_back(r);                           // coincident
		r.bc = pk_c(2 * ONE, 0, 0); rows.push_back(r);  // touching faces
		r.bc = pk_c(2 * ONE + 1, 0, 0); r.want = 0; rows.push_back(r);  // just apart
		r.bc = pk_c(0, 0, -(2 * ONE + 1)); rows.push_back(r);
		r.bc = pk_c(0, -2 * ONE, 0); r.want = 1; rows.push_back(r);
		// centers at opposite extremes, zero extents
		r.ac = pk_c((1 << (CENTER_BITS - 1)) - 1, (1 << (CENTER_BITS - 1)) - 1,
			(1 << (CENTER_BITS - 1)) - 1);
		r.bc = pk_c(-(1 << (CENTER_BITS - 1)), -(1 << (CENTER_BITS - 1)),
			-(1 << (CENTER_BITS - 1)));
		r.ae = '0; r.be = '0; r.want = 0; rows.push_back(r);
		// extremes everywhere: left to the predictor
		r = z; r.want_en = 0;
		r.ac = '1; r.bc = '0; r.a1 = '1; r.a2 = '1; r.a3 = '1;
		r.b1 = '1; r.b2 = '1; r.b3 = '1; r.ae = '1; r.be = '1;
		rows.push_back(r);
		r.a1 = pk_a(32767, -32768, 32767); r.a2 = pk_a(-32768, 32767, -32768);
		r.a3 = pk_a(32767, 32767, -32768); r.b1 = pk_a(-32768, -32768, 32767);
		r.b2 = pk_a(32767, -32768, -32768); r.b3 = pk_a(-32768, 32767, 32767);
		rows.push_back(r);
		r.ac = pk_c((1 << (CENTER_BITS - 1)) - 1, -(1 << (CENTER_BITS - 1)), 0);
		r.bc = pk_c(-(1 << (CENTER_BITS - 1)), (1 << (CENTER_BITS - 1)) - 1, 1);
		rows.push_back(r);
		// non-unit, skewed axes; B rotated 45 degrees about z
		r = z; r.want_en = 0;
		r.a1 = pk_a(3 * ONE, 5, 0); r.a2 = pk_a(7, ONE / 3, 100); r.a3 = pk_a(0, 0, ONE);
		r.b1 = pk_a(2896, 2896, 0); r.b2 = pk_a(-2896, 2896, 0); r.b3 = pk_a(0, 0, ONE);
		r.ae = pk_e(ONE, 2 * ONE, ONE / 2); r.be = pk_e(ONE, ONE, ONE);
		r.bc = pk_c(3 * ONE, ONE, 0);
		rows.push_back(r);
		r.bc = pk_c(ONE, ONE, ONE); rows.push_back(r);
		// only A has axes; B null so only three axes count
		r = z; r.want_en = 0;
		r.a1 = pk_a(ONE, 0, 0); r.a2 = pk_a(0, ONE, 0); r.a3 = pk_a(0, 0, ONE);
		r.ae = pk_e(ONE, ONE, ONE); r.be = '1; r.bc = pk_c(5 * ONE, 0, 0);
		rows.push_back(r);

		#5;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (i % 3 == 2) idle_gap();
			put_pair(rows[i]);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT) begin
				// hold the sender until the pipe is empty
				in_valid = 1'b0;
				while (verdict_q.size() != 0) @(negedge clk);
			end
			idle_gap();
			put_pair(rnd_pair());
		end
		in_valid = 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && verdict_q.size() == 0)
			$display("obb_separating_axis_test_tb OK");
		else
			$display("obb_separating_axis_test_tb NOT OK");
		$finish;
	end
endmodule
